### src/lcag_pkg.sv
// ----------------------------------------------------------------------------
// Game of life grid package
// Shared operation codes, field widths and the sequencer-to-grid control word.
// ----------------------------------------------------------------------------
package lcag_pkg;

	localparam int OP_W    = 2;
	localparam int COL_W   = 4;
	localparam int ROW_W   = 4;
	localparam int OUT_W   = 16;
	localparam int IN_TD_W = 16;

	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic start;  // clear the previous-row register
		logic shift;  // rotate the row store by one row
		logic step;   // write back the next generation
		logic set;    // write back the row with the set mask applied
		logic last;   // the row at the head is the bottom row
	} lcag_ctl_t;

endpackage

### src/lcag_row_unit.sv
// ----------------------------------------------------------------------------
// Game of life row evaluator
// Computes one row of the next generation from three neighboring rows.
// ----------------------------------------------------------------------------
module lcag_row_unit
	import lcag_pkg::*;
#(
	parameter int GRID_SIZE = 16
) (
	input  logic [GRID_SIZE-1:0] above,
	input  logic [GRID_SIZE-1:0] mid,
	input  logic [GRID_SIZE-1:0] below,
	output logic [GRID_SIZE-1:0] next_row
);

	logic [GRID_SIZE+1:0] pad_a;
	logic [GRID_SIZE+1:0] pad_m;
	logic [GRID_SIZE+1:0] pad_b;

	// Cells off the grid edge count as dead.
	assign pad_a = {1'b0, above, 1'b0};
	assign pad_m = {1'b0, mid, 1'b0};
	assign pad_b = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		for (int k = 0; k < GRID_SIZE; k++) begin
			n = 4'(pad_a[k]) + 4'(pad_a[k+1]) + 4'(pad_a[k+2])
			  + 4'(pad_m[k]) + 4'(pad_m[k+2])
			  + 4'(pad_b[k]) + 4'(pad_b[k+1]) + 4'(pad_b[k+2]);
			next_row[k] = (n == 4'd3) || (mid[k] && (n == 4'd2));
		end
	end

endmodule

### src/lcag_grid.sv
// ----------------------------------------------------------------------------
// Game of life rotating row store
// Holds the grid as a ring of rows and rewrites the head row on each shift.
// ----------------------------------------------------------------------------
module lcag_grid
	import lcag_pkg::*;
#(
	parameter int GRID_SIZE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcag_ctl_t            ctl,
	input  logic [COL_W-1:0]     set_col,
	output logic [GRID_SIZE-1:0] head_row
);

	logic [GRID_SIZE-1:0] rows_q [GRID_SIZE];
	logic [GRID_SIZE-1:0] prev_q;
	logic [GRID_SIZE-1:0] below;
	logic [GRID_SIZE-1:0] next_row;
	logic [GRID_SIZE-1:0] set_mask;

	assign below = ctl.last ? '0 : rows_q[1];

	lcag_row_unit #(
		.GRID_SIZE(GRID_SIZE)
	) u_row_unit (
		.above   (prev_q),
		.mid     (rows_q[0]),
		.below   (below),
		.next_row(next_row)
	);

	always_comb begin
		for (int k = 0; k < GRID_SIZE; k++) begin
			set_mask[k] = ctl.set && (int'(set_col) == k);
		end
	end

	// Row written back at the tail: new generation, or the head with the set bit.
	assign head_row = ctl.step ? next_row : (rows_q[0] | set_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int i = 0; i < GRID_SIZE; i++) begin
				rows_q[i] <= '0;
			end
		end else if (ctl.start) begin
			prev_q <= '0;
		end else if (ctl.shift) begin
			prev_q <= rows_q[0];
			for (int i = 0; i < GRID_SIZE - 1; i++) begin
				rows_q[i] <= rows_q[i+1];
			end
			rows_q[GRID_SIZE-1] <= head_row;
		end
	end

endmodule

### src/life_cellular_automaton_grid_top.sv
// ----------------------------------------------------------------------------
// Game of life grid, rule B3/S23
// Square grid of one-bit cells with set, advance and read operations.
// ----------------------------------------------------------------------------
// A new transaction is accepted only after the previous one has finished its turn of the row ring,
//   which passes one row per cycle through the single shared row evaluator.
// Every operation, set and read included, makes one full turn of the ring.
// Reset (arst_n low) kills all cells and empties the output register at once.
module life_cellular_automaton_grid_top
	import lcag_pkg::*;
#(
	parameter int GRID_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [1:0] operation, [5:2] cell_column, [9:6] cell_row, [15:10] zero
	input  logic [IN_TD_W-1:0] s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [15:0] row_cells
	output logic [OUT_W-1:0]   m_axis_tdata
);

	localparam int CntW = $clog2(GRID_SIZE);
	localparam int CmpW = (CntW > ROW_W) ? CntW : ROW_W;
	localparam int ExtW = (GRID_SIZE > OUT_W) ? GRID_SIZE : OUT_W;
	localparam logic [CntW-1:0] LastCnt = CntW'(GRID_SIZE - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [CntW-1:0]      cnt_q;
	logic [OP_W-1:0]      op_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [OUT_W-1:0]     res_q;
	logic                 accept;
	logic                 out_free;
	logic                 row_hit;
	logic                 cnt_last;
	lcag_ctl_t            ctl;
	logic [GRID_SIZE-1:0] head_row;
	logic [ExtW-1:0]      head_ext;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	// Take a new transaction when idle, or when the finished result moves out now.
	assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);

	assign cnt_last = (cnt_q == LastCnt);
	assign row_hit  = (CmpW'(cnt_q) == CmpW'(row_q));

	// Drive the ring: one row per cycle while running. A set touches only the
	// addressed row as it passes the head.
	always_comb begin
		ctl.start = accept;
		ctl.shift = (state_q == ST_RUN);
		ctl.step  = (op_q == OP_STEP);
		ctl.set   = (op_q == OP_SET) && row_hit;
		ctl.last  = cnt_last;
	end

	lcag_grid #(
		.GRID_SIZE(GRID_SIZE)
	) u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.set_col (col_q),
		.head_row(head_row)
	);

	// Report only the low columns; zero-fill narrow grids.
	assign head_ext = ExtW'(head_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			op_q          <= OP_READ;
			m_axis_tvalid <= 1'b0;
		end else begin
			// Present a finished result, or drop valid once it has moved out.
			if ((state_q == ST_DONE) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_last) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					// Hold the result until the output register frees up.
					if (out_free) begin
						state_q <= accept ? ST_RUN : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (accept) begin
				cnt_q <= '0;
				op_q  <= s_axis_tdata[OP_W-1:0];
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= s_axis_tdata[OP_W +: COL_W];
			row_q <= s_axis_tdata[OP_W+COL_W +: ROW_W];
			res_q <= '0;  // rows off the grid never hit and report zero
		end else if ((state_q == ST_RUN) && row_hit) begin
			res_q <= head_ext[OUT_W-1:0];
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_axis_tdata <= res_q;
		end
	end

`ifndef SYNTH
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !s_axis_tready)
		else $error("input ready while the ring is turning");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LastCnt)
		else $error("row counter beyond the grid");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && out_free) |=> m_axis_tvalid)
		else $error("finished result not presented");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the done state");
`endif

endmodule
